// ===== sv/text_console_cursor_engine_top_defines.svh =====
// Assertion macros shared by the text console cursor engine RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tcce_pkg.sv =====
// Shared types, codes and constants of the text console cursor engine.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package tcce_pkg;

  localparam int unsigned LINE_SIZE_DEF = 64;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned GCNT_W  = 9;
  localparam int unsigned MLEN_W  = 7;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned CFG_W   = 9;

  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_QMARK = 8'h3F;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [POS_W-1:0]  COLS_RST   = 8'd80;
  localparam logic [POS_W-1:0]  ROWS_RST   = 8'd25;
  localparam logic [GCNT_W-1:0] GLYPHS_RST = 9'd256;

  typedef enum logic [2:0] {
    REQ_PUT    = 3'd0,
    REQ_KEY    = 3'd1,
    REQ_READ   = 3'd2,
    REQ_CLS    = 3'd3,
    REQ_STATUS = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    KIND_DRAW   = 3'd0,
    KIND_CELL   = 3'd1,
    KIND_SCROLL = 3'd2,
    KIND_CLS    = 3'd3,
    KIND_CHAR   = 3'd4,
    KIND_EMPTY  = 3'd5,
    KIND_STATUS = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    CFG_ENABLED = 2'd0,
    CFG_COLS    = 2'd1,
    CFG_ROWS    = 2'd2,
    CFG_GLYPHS  = 2'd3
  } cfg_idx_e;

  // What an accepted request needs from the sequencer.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_DRAW,
    ACT_SCROLL,
    ACT_CELL,
    ACT_ONE,
    ACT_READ
  } act_e;

  // Which result the datapath loads into the output register.
  typedef enum logic [2:0] {
    EM_NONE,
    EM_DRAW,
    EM_SCROLL,
    EM_CELL,
    EM_ONE,
    EM_READ
  } emit_e;

  typedef struct packed {
    logic  accept;
    emit_e emit;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic draw_scroll;
    logic tab_more;
    logic rd_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/tcce_ctrl.sv =====
// Sequencer of the text console cursor engine: accepts requests and steps
// through their results. Depends on tcce_pkg and the shared assertion macros.
`default_nettype none
`include "text_console_cursor_engine_top_defines.svh"

module tcce_ctrl
  import tcce_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAW,
    S_SCROLL,
    S_CELL,
    S_ONE,
    S_READ
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o.accept = in_valid_i && (state_q == S_IDLE);
    cmd_o.emit   = EM_NONE;
    state_d      = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (stat_i.act)
            ACT_DRAW:   state_d = S_DRAW;
            ACT_SCROLL: state_d = S_SCROLL;
            ACT_CELL:   state_d = S_CELL;
            ACT_ONE:    state_d = S_ONE;
            ACT_READ:   state_d = S_READ;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_DRAW: begin
        if (stat_i.out_free) begin
          cmd_o.emit = EM_DRAW;
          if (stat_i.draw_scroll) begin
            state_d = S_SCROLL;
          end else if (stat_i.tab_more) begin
            state_d = S_DRAW;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SCROLL: begin
        if (stat_i.out_free) begin
          cmd_o.emit = EM_SCROLL;
          state_d    = stat_i.tab_more ? S_DRAW : S_IDLE;
        end
      end
      S_CELL: begin
        if (stat_i.out_free) begin
          cmd_o.emit = EM_CELL;
          state_d    = S_IDLE;
        end
      end
      S_ONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = EM_ONE;
          state_d    = S_IDLE;
        end
      end
      S_READ: begin
        if (stat_i.out_free) begin
          cmd_o.emit = EM_READ;
          if (stat_i.rd_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TCCE_ASSERT_IMPL(a_emit_into_free_slot, cmd_o.emit != EM_NONE, stat_i.out_free,
                    "result loaded while the output register is held")
  `TCCE_ASSERT_NEXT(a_read_ends_idle, state_q == S_READ && stat_i.out_free && stat_i.rd_last,
                    state_q == S_IDLE, "read did not finish after its final character")
  `TCCE_ASSERT_NEXT(a_wrap_scrolls, state_q == S_DRAW && stat_i.out_free && stat_i.draw_scroll,
                    state_q == S_SCROLL, "wrap at the bottom row did not scroll")

endmodule

`default_nettype wire

// ===== sv/tcce_dp.sv =====
// Datapath of the text console cursor engine: registers, cursor, line store,
// request decode and output register. Depends on tcce_pkg.
`default_nettype none

module tcce_dp
  import tcce_pkg::*;
#(
  parameter int unsigned LINE_SIZE = LINE_SIZE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [2:0]           req_type_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic [MLEN_W-1:0]    max_len_i,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           kind_o,
  output logic [POS_W-1:0]     col_o,
  output logic [POS_W-1:0]     row_o,
  output logic [CHAR_W-1:0]    glyph_code_o,
  output logic [LEN_W-1:0]     line_length_o,
  output logic                 line_is_ready_o,
  output logic                 last_o
);

  localparam int unsigned CW = $clog2(LINE_SIZE);
  localparam logic [CW:0] LS_W = (CW+1)'(LINE_SIZE);

  // Configuration registers.
  logic              en_q;
  logic [POS_W-1:0]  cols_q, rows_q;
  logic [GCNT_W-1:0] glyphs_q;

  // Console state.
  logic [POS_W-1:0]  ccol_q, ccol_d, crow_q, crow_d;
  logic [CW-1:0]     count_q, count_d;
  logic              done_q, done_d;
  logic [CHAR_W-1:0] line_mem [LINE_SIZE];
  logic [CHAR_W-1:0] rdata_q;
  logic [CW-1:0]     raddr;
  logic              wr_en;

  // Per-request working registers.
  logic [1:0]        tab_q, tab_d;
  logic [CHAR_W-1:0] glyph_q, glyph_d;
  kind_e             one_kind_q, one_kind_d;
  logic [CW-1:0]     rlen_q, rlen_d, res_len_q, res_len_d;
  logic [CW-1:0]     ridx_q, ridx_d;

  // Output register.
  logic              ov_q, ov_d;
  kind_e             okind_q, okind_d;
  logic [POS_W-1:0]  ocol_q, ocol_d, orow_q, orow_d;
  logic [CHAR_W-1:0] oglyph_q, oglyph_d;
  logic [CW-1:0]     olen_q, olen_d;
  logic              ordy_q, ordy_d, olast_q, olast_d;

  logic [POS_W-1:0]  cols_eff, rows_eff;
  logic              wrap, draw_scroll, nl_scroll, tab_more;
  logic              put_go, rd_go;
  logic [CHAR_W-1:0] draw_ch;
  logic [MLEN_W-1:0] cnt7, rl7;
  act_e              act;

  assign cols_eff    = (cols_q == '0) ? POS_W'(1) : cols_q;
  assign rows_eff    = (rows_q == '0) ? POS_W'(1) : rows_q;
  assign wrap        = ({1'b0, ccol_q} + 9'd1) >= {1'b0, cols_eff};
  assign nl_scroll   = ({1'b0, crow_q} + 9'd1) >= {1'b0, rows_eff};
  assign draw_scroll = wrap && nl_scroll;
  assign tab_more    = (tab_q != 2'd0);
  assign draw_ch     = (char_code_i == CHAR_TAB) ? CHAR_SPACE : char_code_i;

  assign cnt7 = MLEN_W'(count_q);
  assign rl7  = (cnt7 >= max_len_i) ? (max_len_i - MLEN_W'(1)) : cnt7;

  // Request decode and the state changes made at acceptance.
  always_comb begin
    act        = ACT_NONE;
    put_go     = 1'b0;
    rd_go      = 1'b0;
    wr_en      = 1'b0;
    one_kind_d = one_kind_q;
    ccol_d     = ccol_q;
    crow_d     = crow_q;
    count_d    = count_q;
    done_d     = done_q;
    rlen_d     = rlen_q;
    case (req_type_i)
      REQ_PUT: put_go = en_q;
      REQ_KEY: begin
        if (en_q && !done_q) begin
          if (char_code_i == CHAR_NL) begin
            put_go = 1'b1;
            done_d = 1'b1;
          end else if (char_code_i == CHAR_BS) begin
            if (count_q != '0) begin
              put_go  = 1'b1;
              count_d = count_q - CW'(1);
            end
          end else if (({1'b0, count_q} + (CW+1)'(1)) < LS_W) begin
            put_go  = 1'b1;
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
      end
      REQ_READ: begin
        rd_go      = (max_len_i != '0) && done_q;
        rlen_d     = rd_go ? CW'(rl7) : '0;
        one_kind_d = KIND_EMPTY;
        if (rd_go) begin
          count_d = '0;
          done_d  = 1'b0;
        end
        act = (rd_go && rl7 != '0) ? ACT_READ : ACT_ONE;
      end
      REQ_CLS: begin
        if (en_q) begin
          act        = ACT_ONE;
          one_kind_d = KIND_CLS;
          ccol_d     = '0;
          crow_d     = '0;
        end
      end
      REQ_STATUS: begin
        act        = ACT_ONE;
        one_kind_d = KIND_STATUS;
      end
      default: act = ACT_NONE;
    endcase
    if (put_go) begin
      case (char_code_i)
        CHAR_NL: begin
          ccol_d = '0;
          if (nl_scroll) begin
            crow_d = rows_eff - POS_W'(1);
            act    = ACT_SCROLL;
          end else begin
            crow_d = crow_q + POS_W'(1);
          end
        end
        CHAR_CR: ccol_d = '0;
        CHAR_BS: begin
          if (ccol_q != '0) begin
            ccol_d = ccol_q - POS_W'(1);
            act    = ACT_CELL;
          end
        end
        default: act = ACT_DRAW;
      endcase
    end
    res_len_d = (req_type_i == REQ_READ) ? rlen_d : count_d;
  end

  assign stat_o.act         = act;
  assign stat_o.draw_scroll = draw_scroll;
  assign stat_o.tab_more    = tab_more;
  assign stat_o.rd_last     = ({1'b0, ridx_q} + (CW+1)'(1)) == {1'b0, rlen_q};
  assign stat_o.out_free    = !ov_q || !out_stall_i;

  // Line store fetched ahead so an unstalled read streams one character a cycle.
  always_comb begin
    if (cmd_i.accept) begin
      raddr = '0;
    end else if (cmd_i.emit == EM_READ) begin
      raddr = ridx_q + CW'(1);
    end else begin
      raddr = ridx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_en) begin
      line_mem[count_q] <= char_code_i;
    end
    rdata_q <= line_mem[raddr];
  end

  // Emission: load the output register and advance the cursor or read index.
  always_comb begin
    tab_d    = tab_q;
    glyph_d  = glyph_q;
    ridx_d   = ridx_q;
    ov_d     = ov_q && out_stall_i;
    okind_d  = okind_q;
    ocol_d   = ocol_q;
    orow_d   = orow_q;
    oglyph_d = oglyph_q;
    olen_d   = olen_q;
    ordy_d   = ordy_q;
    olast_d  = olast_q;
    if (cmd_i.accept) begin
      tab_d   = (char_code_i == CHAR_TAB) ? 2'd3 : 2'd0;
      glyph_d = ({1'b0, draw_ch} >= glyphs_q) ? CHAR_QMARK : draw_ch;
      ridx_d  = '0;
    end
    if (cmd_i.emit != EM_NONE) begin
      ov_d     = 1'b1;
      ocol_d   = '0;
      orow_d   = '0;
      oglyph_d = '0;
      olen_d   = res_len_q;
      ordy_d   = done_q;
      olast_d  = 1'b1;
      case (cmd_i.emit)
        EM_DRAW: begin
          okind_d  = KIND_DRAW;
          ocol_d   = ccol_q;
          orow_d   = crow_q;
          oglyph_d = glyph_q;
          olast_d  = !draw_scroll && !tab_more;
          if (!draw_scroll && tab_more) begin
            tab_d = tab_q - 2'd1;
          end
        end
        EM_SCROLL: begin
          okind_d = KIND_SCROLL;
          olast_d = !tab_more;
          if (tab_more) begin
            tab_d = tab_q - 2'd1;
          end
        end
        EM_CELL: begin
          okind_d = KIND_CELL;
          ocol_d  = ccol_q;
          orow_d  = crow_q;
        end
        EM_ONE: okind_d = one_kind_q;
        EM_READ: begin
          okind_d  = KIND_CHAR;
          oglyph_d = rdata_q;
          olast_d  = stat_o.rd_last;
          ridx_d   = ridx_q + CW'(1);
        end
        default: okind_d = okind_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      cols_q   <= COLS_RST;
      rows_q   <= ROWS_RST;
      glyphs_q <= GLYPHS_RST;
      ccol_q   <= '0;
      crow_q   <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ENABLED: en_q     <= cfg_data_i[0];
          CFG_COLS:    cols_q   <= cfg_data_i[POS_W-1:0];
          CFG_ROWS:    rows_q   <= cfg_data_i[POS_W-1:0];
          CFG_GLYPHS:  glyphs_q <= cfg_data_i;
          default:     en_q     <= en_q;
        endcase
      end
      if (cmd_i.accept) begin
        ccol_q  <= ccol_d;
        crow_q  <= crow_d;
        count_q <= count_d;
        done_q  <= done_d;
      end else if (cmd_i.emit == EM_DRAW) begin
        if (wrap) begin
          ccol_q <= '0;
          crow_q <= nl_scroll ? (rows_eff - POS_W'(1)) : (crow_q + POS_W'(1));
        end else begin
          ccol_q <= ccol_q + POS_W'(1);
        end
      end
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      one_kind_q <= one_kind_d;
      rlen_q     <= rlen_d;
      res_len_q  <= res_len_d;
    end
    tab_q    <= tab_d;
    glyph_q  <= glyph_d;
    ridx_q   <= ridx_d;
    okind_q  <= okind_d;
    ocol_q   <= ocol_d;
    orow_q   <= orow_d;
    oglyph_q <= oglyph_d;
    olen_q   <= olen_d;
    ordy_q   <= ordy_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o     = ov_q;
  assign kind_o          = okind_q;
  assign col_o           = ocol_q;
  assign row_o           = orow_q;
  assign glyph_code_o    = oglyph_q;
  assign line_length_o   = LEN_W'(olen_q);
  assign line_is_ready_o = ordy_q;
  assign last_o          = olast_q;

endmodule

`default_nettype wire

// ===== sv/text_console_cursor_engine_top.sv =====
// Text console cursor engine. Requests (put character, keyboard input, read
// line, clear screen, status) are taken one at a time; the engine then issues
// its results one per cycle from an output register while the output is not
// stalled: none for a carriage return, one for most characters, up to eight for
// a tab that wraps and scrolls, and up to LINE_SIZE-1 characters for a read.
// The input is stalled until the last result is loaded. The sequencer, not the
// datapath, sets this pace. The line store is a single-port-read memory whose
// read address runs one entry ahead, which lets a read stream one character per
// cycle while the output is not stalled. Configuration is written through a
// port that is always ready. Depends on tcce_pkg, tcce_ctrl and tcce_dp.
`default_nettype none

module text_console_cursor_engine_top
  import tcce_pkg::*;
#(
  parameter int unsigned LINE_SIZE = LINE_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        req_type_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [MLEN_W-1:0] max_len_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        kind_o,
  output logic [POS_W-1:0]  col_o,
  output logic [POS_W-1:0]  row_o,
  output logic [CHAR_W-1:0] glyph_code_o,
  output logic [LEN_W-1:0]  line_length_o,
  output logic              line_is_ready_o,
  output logic              last_o
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  tcce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tcce_dp #(
    .LINE_SIZE (LINE_SIZE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .char_code_i     (char_code_i),
    .max_len_i       (max_len_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .col_o           (col_o),
    .row_o           (row_o),
    .glyph_code_o    (glyph_code_o),
    .line_length_o   (line_length_o),
    .line_is_ready_o (line_is_ready_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire
